@@ rtl/srd_pkg.sv @@
`default_nettype none

package srd_pkg;

    localparam logic [7:0] SYM_FEND  = 8'hC0;
    localparam logic [7:0] SYM_FESC  = 8'hDB;
    localparam logic [7:0] SYM_TFEND = 8'hDC;
    localparam logic [7:0] SYM_TFESC = 8'hDD;

    localparam int CFG_W   = 11;
    localparam int INDEX_W = 10;
    localparam int LEN_W   = 11;

    typedef enum logic [1:0] {
        ERR_NONE       = 2'd0,
        ERR_OVERFLOW   = 2'd1,
        ERR_BAD_ESCAPE = 2'd2
    } srd_err_t;

    typedef struct packed {
        logic               byte_valid;
        logic [7:0]         byte_value;
        logic [INDEX_W-1:0] byte_index;
        logic               frame_done;
        logic [LEN_W-1:0]   frame_length;
        srd_err_t           error_code;
    } srd_result_t;

endpackage

`default_nettype wire

@@ rtl/srd_stage.sv @@
`default_nettype none

// One pipeline register with valid/stall flow control.
module srd_stage #(
    parameter int WIDTH = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire logic [WIDTH-1:0] in_data,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output logic      [WIDTH-1:0] out_data
);

    logic             valid_reg;
    logic             valid_next;
    logic [WIDTH-1:0] data_reg;
    logic             load;

    // The register takes a new item whenever it is empty or its item leaves.
    assign in_stall   = valid_reg && out_stall;
    assign load       = in_valid && !in_stall;
    assign valid_next = load || (valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= in_data;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

@@ rtl/srd_decode.sv @@
`default_nettype none

module srd_decode
    import srd_pkg::*;
#(
    parameter int MAX_FRAME_DEPTH = 1024
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             fire,
    input  wire logic [7:0]       rx_byte,
    input  wire logic             cfg_write,
    input  wire logic [CFG_W-1:0] cfg_data,
    output srd_result_t           result
);

    // The limit never exceeds the largest register value, so the position
    // needs at most as many bits as the register.
    localparam int DEPTH_BITS = $clog2(MAX_FRAME_DEPTH + 1);
    localparam int POS_W = (DEPTH_BITS > CFG_W) ? CFG_W : DEPTH_BITS;
    localparam int LIMIT_RESET = (MAX_FRAME_DEPTH < 1024) ? MAX_FRAME_DEPTH : 1024;

    logic             in_sync_reg;
    logic             in_sync_next;
    logic             escape_reg;
    logic             escape_next;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [POS_W-1:0] limit_reg;
    logic [POS_W-1:0] limit_next;
    logic [LEN_W-1:0] pos_wide;
    logic             cfg_over;

    // Saturate the configured maximum to the frame depth as it is written.
    assign cfg_over   = 32'(cfg_data) > 32'(MAX_FRAME_DEPTH);
    assign limit_next = cfg_over ? POS_W'(MAX_FRAME_DEPTH) : POS_W'(cfg_data);

    assign pos_wide = LEN_W'(pos_reg);

    always_comb
    begin
        in_sync_next = in_sync_reg;
        escape_next  = escape_reg;
        pos_next     = pos_reg;
        result       = '0;

        if (!in_sync_reg)
        begin
            if (rx_byte == SYM_FEND)
            begin
                in_sync_next = 1'b1;
            end
        end
        else if (rx_byte == SYM_FEND)
        begin
            if (pos_reg != '0)
            begin
                result.frame_done   = 1'b1;
                result.frame_length = pos_wide;
                pos_next            = '0;
                escape_next         = 1'b0;
            end
        end
        else if (pos_reg >= limit_reg)
        begin
            result.error_code = ERR_OVERFLOW;
            in_sync_next      = 1'b0;
            escape_next       = 1'b0;
            pos_next          = '0;
        end
        else if (escape_reg)
        begin
            if (rx_byte == SYM_TFESC || rx_byte == SYM_TFEND)
            begin
                result.byte_valid = 1'b1;
                result.byte_value = (rx_byte == SYM_TFESC) ? SYM_FESC : SYM_FEND;
                result.byte_index = pos_wide[INDEX_W-1:0];
                pos_next          = pos_reg + 1'b1;
                escape_next       = 1'b0;
            end
            else
            begin
                result.error_code = ERR_BAD_ESCAPE;
                in_sync_next      = 1'b0;
                escape_next       = 1'b0;
                pos_next          = '0;
            end
        end
        else if (rx_byte == SYM_FESC)
        begin
            escape_next = 1'b1;
        end
        else
        begin
            result.byte_valid = 1'b1;
            result.byte_value = rx_byte;
            result.byte_index = pos_wide[INDEX_W-1:0];
            pos_next          = pos_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_sync_reg <= 1'b0;
            escape_reg  <= 1'b0;
            pos_reg     <= '0;
            limit_reg   <= POS_W'(LIMIT_RESET);
        end
        else
        begin
            if (fire)
            begin
                in_sync_reg <= in_sync_next;
                escape_reg  <= escape_next;
                pos_reg     <= pos_next;
            end
            if (cfg_write)
            begin
                limit_reg <= limit_next;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_error_drops_sync: assert property (@(posedge clk) disable iff (!rst_n)
        fire && result.error_code != ERR_NONE |=> !in_sync_reg && pos_reg == '0)
        else $error("error did not drop sync");

    a_hunt_is_clean: assert property (@(posedge clk) disable iff (!rst_n)
        !in_sync_reg |-> pos_reg == '0 && !escape_reg)
        else $error("state left over while hunting");

    a_done_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        fire && result.frame_done |=> pos_reg == '0 && in_sync_reg)
        else $error("frame end did not restart the frame");

    a_byte_advances: assert property (@(posedge clk) disable iff (!rst_n)
        fire && result.byte_valid |=> pos_reg == $past(pos_reg) + 1'b1)
        else $error("position did not advance on a data byte");
`endif

endmodule

`default_nettype wire

@@ rtl/slip_receive_deframer.sv @@
`default_nettype none

// Channel  Handshake           Payload
// input    in_valid/in_stall   rx_byte
// result   out_valid/out_stall byte_valid byte_value byte_index frame_done
//                              frame_length error_code
// config   cfg_valid/cfg_ready max_frame_bytes
//
// Every item gives one result, one item per cycle while the result is not stalled.
// The rate is set by the single decode step between the input and result registers.
// Reset clears sync, escape, position; frame limit = min(MAX_FRAME_DEPTH, 1024) bytes.
// A stalled result holds the result register and then the input register;
// configuration writes are taken in any cycle.
module slip_receive_deframer
    import srd_pkg::*;
#(
    parameter int MAX_FRAME_DEPTH = 1024
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [7:0]         rx_byte,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic                    byte_valid,
    output logic [7:0]              byte_value,
    output logic [INDEX_W-1:0]      byte_index,
    output logic                    frame_done,
    output logic [LEN_W-1:0]        frame_length,
    output logic [1:0]              error_code,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [CFG_W-1:0]   max_frame_bytes
);

    logic        rx_valid;
    logic [7:0]  rx_data;
    logic        res_stall;
    logic        fire;
    srd_result_t res_in;
    srd_result_t res_out;

    assign cfg_ready = 1'b1;

    srd_stage #(
        .WIDTH(8)
    ) u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (rx_byte),
        .out_valid(rx_valid),
        .out_stall(res_stall),
        .out_data (rx_data)
    );

    assign fire = rx_valid && !res_stall;

    srd_decode #(
        .MAX_FRAME_DEPTH(MAX_FRAME_DEPTH)
    ) u_decode (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (fire),
        .rx_byte  (rx_data),
        .cfg_write(cfg_valid && cfg_ready),
        .cfg_data (max_frame_bytes),
        .result   (res_in)
    );

    srd_stage #(
        .WIDTH($bits(srd_result_t))
    ) u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (rx_valid),
        .in_stall (res_stall),
        .in_data  (res_in),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (res_out)
    );

    assign byte_valid   = res_out.byte_valid;
    assign byte_value   = res_out.byte_value;
    assign byte_index   = res_out.byte_index;
    assign frame_done   = res_out.frame_done;
    assign frame_length = res_out.frame_length;
    assign error_code   = res_out.error_code;

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
`default_nettype none

module tb_top;
    import srd_pkg::*;

    localparam int FRAME_DEPTH  = 1024;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int RANDOM_ITEMS = 450;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [7:0]         rx_byte;
    logic               out_valid;
    logic               out_stall;
    logic               byte_valid;
    logic [7:0]         byte_value;
    logic [INDEX_W-1:0] byte_index;
    logic               frame_done;
    logic [LEN_W-1:0]   frame_length;
    logic [1:0]         error_code;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [CFG_W-1:0]   max_frame_bytes;

    // Decoder state as the testbench sees it.
    bit               synced;
    bit               escape_armed;
    int               fill_count;
    logic [CFG_W-1:0] frame_cap;

    srd_result_t decoded_q[$];
    int          fault_count;
    int          items_sent;
    int          cycle_count;
    int          gap_per_16;
    int          stall_per_16;

    slip_receive_deframer #(
        .MAX_FRAME_DEPTH(FRAME_DEPTH)
    ) uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .rx_byte         (rx_byte),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .byte_valid      (byte_valid),
        .byte_value      (byte_value),
        .byte_index      (byte_index),
        .frame_done      (frame_done),
        .frame_length    (frame_length),
        .error_code      (error_code),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .max_frame_bytes (max_frame_bytes)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int frame_limit_now();
        return (frame_cap > FRAME_DEPTH) ? FRAME_DEPTH : int'(frame_cap);
    endfunction

    function automatic void lose_sync();
        synced       = 1'b0;
        escape_armed = 1'b0;
        fill_count   = 0;
    endfunction

    task automatic decode_byte(input logic [7:0] b, output srd_result_t r);
        r = '0;
        if (!synced)
        begin
            if (b == SYM_FEND)
                synced = 1'b1;
        end
        else if (b == SYM_FEND)
        begin
            // A closing FEND on an empty frame leaves even a pending escape alone.
            if (fill_count != 0)
            begin
                r.frame_done   = 1'b1;
                r.frame_length = LEN_W'(fill_count);
                fill_count     = 0;
                escape_armed   = 1'b0;
            end
        end
        else if (fill_count >= frame_limit_now())
        begin
            r.error_code = ERR_OVERFLOW;
            lose_sync();
        end
        else if (escape_armed)
        begin
            if (b == SYM_TFEND || b == SYM_TFESC)
            begin
                r.byte_valid = 1'b1;
                r.byte_value = (b == SYM_TFESC) ? SYM_FESC : SYM_FEND;
                r.byte_index = INDEX_W'(fill_count);
                fill_count++;
                escape_armed = 1'b0;
            end
            else
            begin
                r.error_code = ERR_BAD_ESCAPE;
                lose_sync();
            end
        end
        else if (b == SYM_FESC)
        begin
            escape_armed = 1'b1;
        end
        else
        begin
            r.byte_valid = 1'b1;
            r.byte_value = b;
            r.byte_index = INDEX_W'(fill_count);
            fill_count++;
        end
    endtask

    // Called at a falling edge; returns at a falling edge with in_valid still high.
    task automatic send_byte(input logic [7:0] b);
        srd_result_t r;
        if ($urandom_range(0, 15) < gap_per_16)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        decode_byte(b, r);
        decoded_q.push_back(r);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_encoded(input logic [7:0] b);
        if (b == SYM_FEND)
        begin
            send_byte(SYM_FESC);
            send_byte(SYM_TFEND);
        end
        else if (b == SYM_FESC)
        begin
            send_byte(SYM_FESC);
            send_byte(SYM_TFESC);
        end
        else
        begin
            send_byte(b);
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (decoded_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_frame_cap(input logic [CFG_W-1:0] cap);
        cfg_valid       <= 1'b1;
        max_frame_bytes <= cap;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        frame_cap = cap;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] pick_line_byte();
        case ($urandom_range(0, 15))
            0, 1:    return SYM_FEND;
            2, 3:    return SYM_FESC;
            4:       return SYM_TFEND;
            5:       return SYM_TFESC;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_random_frame(input bit broken);
        int         lim;
        int         n;
        logic [7:0] bad;
        lim = frame_limit_now();
        n   = $urandom_range(0, (lim < 20) ? lim + 2 : 20);
        send_byte(SYM_FEND);
        for (int i = 0; i < n; i++)
        begin
            if (broken && i == n / 2)
            begin
                case ($urandom_range(0, 2))
                    0: bad = SYM_FEND;
                    1: bad = SYM_FESC;
                    default:
                    begin
                        do
                            bad = 8'($urandom_range(0, 255));
                        while (bad == SYM_TFEND || bad == SYM_TFESC);
                    end
                endcase
                send_byte(SYM_FESC);
                send_byte(bad);
            end
            else
            begin
                send_encoded(pick_line_byte());
            end
        end
        send_byte(SYM_FEND);
    endtask

    task automatic test_directed_decode();
        // Out of sync: everything but FEND is ignored.
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(SYM_FESC);
        send_byte(SYM_FEND);
        send_byte(SYM_FEND);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(SYM_FESC);
        send_byte(SYM_TFEND);
        send_byte(SYM_FESC);
        send_byte(SYM_TFESC);
        send_byte(SYM_FEND);
        // An empty-frame FEND keeps the escape pending.
        send_byte(SYM_FESC);
        send_byte(SYM_FEND);
        send_byte(SYM_TFESC);
        // A FEND after an escape closes the frame and clears the escape.
        send_byte(SYM_FESC);
        send_byte(SYM_FEND);
        send_byte(8'h41);
        send_byte(SYM_FEND);
        send_byte(SYM_FESC);
        send_byte(8'h41);
        send_byte(SYM_FEND);
        send_byte(SYM_FESC);
        send_byte(SYM_FESC);
        wait_drained();
    endtask

    task automatic test_frame_limits();
        write_frame_cap(11'd3);
        send_byte(SYM_FEND);
        repeat (3) send_byte(8'($urandom_range(0, 191)));
        send_byte(SYM_FEND);
        repeat (3) send_byte(8'($urandom_range(0, 191)));
        send_byte(8'h7E);
        send_byte(SYM_FEND);
        repeat (3) send_byte(8'($urandom_range(0, 191)));
        send_byte(SYM_FESC);
        wait_drained();
        // With a zero limit every non-FEND byte in sync overflows.
        write_frame_cap(11'd0);
        send_byte(SYM_FEND);
        send_byte(8'h55);
        send_byte(SYM_FEND);
        send_byte(SYM_FESC);
        wait_drained();
    endtask

    task automatic test_full_depth();
        // Values above the depth saturate, so a frame fills every index
        // and the byte after it still overflows.
        write_frame_cap(11'd2047);
        send_byte(SYM_FEND);
        repeat (FRAME_DEPTH) send_byte(8'($urandom_range(0, 191)));
        send_byte(8'h5A);
        wait_drained();
    endtask

    task automatic test_random_traffic();
        int               stop_at;
        int               pick;
        logic [CFG_W-1:0] cap;
        stop_at = items_sent + RANDOM_ITEMS;
        while (items_sent < stop_at)
        begin
            wait_drained();
            case ($urandom_range(0, 7))
                0:       cap = 11'd0;
                1:       cap = 11'($urandom_range(1, 4));
                2:       cap = 11'd2047;
                3:       cap = 11'd1024;
                4:       cap = 11'($urandom_range(0, 2047));
                default: cap = 11'($urandom_range(5, 24));
            endcase
            write_frame_cap(cap);
            gap_per_16   = $urandom_range(0, 4);
            stall_per_16 = $urandom_range(0, 4);
            repeat ($urandom_range(8, 20))
            begin
                pick = $urandom_range(0, 9);
                if (pick < 7)
                    send_random_frame(1'b0);
                else if (pick < 9)
                    send_random_frame(1'b1);
                else
                    repeat ($urandom_range(1, 8)) send_byte(pick_line_byte());
                // Now and then hold the input until the pipeline is empty.
                if ($urandom_range(0, 15) == 0)
                    wait_drained();
            end
        end
    endtask

    task automatic test_quiet_tail();
        gap_per_16   = 0;
        stall_per_16 = 0;
        repeat (12) send_random_frame($urandom_range(0, 3) == 0);
    endtask

    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 15) < stall_per_16)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 14)) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        srd_result_t got;
        srd_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got.byte_valid   = byte_valid;
            got.byte_value   = byte_value;
            got.byte_index   = byte_index;
            got.frame_done   = frame_done;
            got.frame_length = frame_length;
            got.error_code   = srd_err_t'(error_code);
            if (decoded_q.size() == 0)
            begin
                fault_count++;
                if (fault_count <= 10)
                    $display("unexpected result: valid=%0b value=%h index=%0d done=%0b len=%0d err=%0d",
                             got.byte_valid, got.byte_value, got.byte_index,
                             got.frame_done, got.frame_length, got.error_code);
            end
            else
            begin
                want = decoded_q.pop_front();
                if (got !== want)
                begin
                    fault_count++;
                    if (fault_count <= 10)
                    begin
                        $display("mismatch expected: valid=%0b value=%h index=%0d done=%0b len=%0d err=%0d",
                                 want.byte_valid, want.byte_value, want.byte_index,
                                 want.frame_done, want.frame_length, want.error_code);
                        $display("         actual:   valid=%0b value=%h index=%0d done=%0b len=%0d err=%0d",
                                 got.byte_valid, got.byte_value, got.byte_index,
                                 got.frame_done, got.frame_length, got.error_code);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        rx_byte         = 8'h00;
        cfg_valid       = 1'b0;
        max_frame_bytes = '0;
        fault_count     = 0;
        items_sent      = 0;
        cycle_count     = 0;
        gap_per_16      = 3;
        stall_per_16    = 3;
        frame_cap       = 11'd1024;
        lose_sync();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed_decode();
        test_frame_limits();
        test_full_depth();
        test_random_traffic();
        test_quiet_tail();
        wait_drained();
        repeat (10) @(posedge clk);

        if (fault_count == 0 && decoded_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire
